FILE: hw/rtl/framed_link_byte_receiver_top_macros.svh
// Assertion macros shared by the frame receiver RTL.
// No dependencies; included by the modules that carry checks.
`ifndef FRAMED_LINK_BYTE_RECEIVER_TOP_MACROS_SVH
`define FRAMED_LINK_BYTE_RECEIVER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define FLBR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FLBR_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define FLBR_ASSERT(lbl, clk, rstn, prop, msg)
`define FLBR_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

FILE: hw/rtl/flbr_pkg.sv
// Types and constants for the framed link byte receiver.
// No dependencies; used by every module of the block.
package flbr_pkg;

    localparam logic [7:0]  SYNC_RESET = 8'h00;
    localparam logic [15:0] GAP_RESET  = 16'd5000;
    localparam logic [16:0] LEN_PAD    = 17'd3;

    localparam logic CFG_SYNC = 1'b0;
    localparam logic CFG_GAP  = 1'b1;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_BAD     = 2'd2;

    typedef enum logic [7:0] {
        PH_HUNT     = 8'b0000_0001,
        PH_DISCARD  = 8'b0000_0010,
        PH_SEQ      = 8'b0000_0100,
        PH_LEN_HI   = 8'b0000_1000,
        PH_LEN_LO   = 8'b0001_0000,
        PH_TYPE     = 8'b0010_0000,
        PH_RESERVED = 8'b0100_0000,
        PH_BODY     = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_data;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [7:0]  frame_type;
        logic [7:0]  frame_sequence;
        logic [15:0] frame_length;
    } t_result;

endpackage

FILE: hw/rtl/flbr_in_stage.sv
// Input register for the receiver: holds one accepted word until the core takes it.
// Depends on flbr_pkg.
`include "framed_link_byte_receiver_top_macros.svh"
module flbr_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  flbr_pkg::t_item  i_item,
    input  logic             i_take,
    output logic             o_valid,
    output flbr_pkg::t_item  o_item
);

    logic            r_valid;
    flbr_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    `FLBR_ASSERT(a_take_needs_word, i_clk, i_rst_n, i_take |-> r_valid,
                 "input stage consumed with no word held")

endmodule

FILE: hw/rtl/flbr_core.sv
// Deframing state machine, checksum lanes and configuration registers.
// Depends on flbr_pkg; one held word is processed per cycle while the output has space.
`include "framed_link_byte_receiver_top_macros.svh"
module flbr_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_addr,
    input  logic [15:0]       i_cfg_wdata,
    input  logic              i_valid,
    input  flbr_pkg::t_item   i_item,
    input  logic              i_space,
    output logic              o_take,
    output logic              o_res_valid,
    output flbr_pkg::t_result o_res
);

    logic [7:0]       r_sync_byte;
    logic [15:0]      r_gap_ticks;
    flbr_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_xor_even, n_xor_even;
    logic [7:0]       r_xor_odd, n_xor_odd;
    logic             r_sel, n_sel;
    logic [7:0]       r_seq, n_seq;
    logic [15:0]      r_len, n_len;
    logic [7:0]       r_type, n_type;
    logic [16:0]      r_body, n_body;
    logic [15:0]      r_quiet, n_quiet;

    logic [7:0]  b;
    logic [16:0] total;
    logic        do_hunt;

    assign o_take  = i_valid && i_space;
    assign b       = i_item.rx_data;
    assign total   = ({1'b0, r_len} + flbr_pkg::LEN_PAD) & ~17'd1;
    assign do_hunt = (r_phase == flbr_pkg::PH_HUNT) ||
                     ((r_phase == flbr_pkg::PH_DISCARD) && (r_quiet >= r_gap_ticks));

    always_comb begin
        n_phase     = r_phase;
        n_xor_even  = r_xor_even;
        n_xor_odd   = r_xor_odd;
        n_sel       = r_sel;
        n_seq       = r_seq;
        n_len       = r_len;
        n_type      = r_type;
        n_body      = r_body;
        n_quiet     = r_quiet;
        o_res_valid = 1'b0;
        o_res.kind           = flbr_pkg::KIND_PAYLOAD;
        o_res.payload_byte   = 8'h00;
        o_res.frame_type     = r_type;
        o_res.frame_sequence = r_seq;
        o_res.frame_length   = r_len;

        if (o_take && (i_item.action == flbr_pkg::ACT_TICK)) begin
            if ((r_phase == flbr_pkg::PH_DISCARD) && (r_quiet != 16'hFFFF)) begin
                n_quiet = r_quiet + 16'd1;
            end
        end else if (o_take) begin
            if (r_sel) begin
                n_xor_odd = r_xor_odd ^ b;
            end else begin
                n_xor_even = r_xor_even ^ b;
            end
            n_sel = !r_sel;

            if (do_hunt) begin
                if (b == r_sync_byte) begin
                    n_xor_even = b;
                    n_xor_odd  = 8'h00;
                    n_sel      = 1'b1;
                    n_phase    = flbr_pkg::PH_SEQ;
                end else begin
                    n_phase = flbr_pkg::PH_DISCARD;
                    n_quiet = 16'd0;
                end
            end else begin
                case (r_phase)
                    flbr_pkg::PH_DISCARD: begin
                        n_quiet = 16'd0;
                    end
                    flbr_pkg::PH_SEQ: begin
                        n_seq   = b;
                        n_phase = flbr_pkg::PH_LEN_HI;
                    end
                    flbr_pkg::PH_LEN_HI: begin
                        n_len   = {b, 8'h00};
                        n_phase = flbr_pkg::PH_LEN_LO;
                    end
                    flbr_pkg::PH_LEN_LO: begin
                        n_len   = {r_len[15:8], b};
                        n_phase = flbr_pkg::PH_TYPE;
                    end
                    flbr_pkg::PH_TYPE: begin
                        n_type  = b;
                        n_phase = flbr_pkg::PH_RESERVED;
                    end
                    flbr_pkg::PH_RESERVED: begin
                        n_body  = 17'd0;
                        n_phase = flbr_pkg::PH_BODY;
                    end
                    flbr_pkg::PH_BODY: begin
                        n_body = r_body + 17'd1;
                        if (r_body < {1'b0, r_len}) begin
                            o_res_valid        = 1'b1;
                            o_res.payload_byte = b;
                        end else if (n_body >= total) begin
                            // verdict uses the lanes after this last word
                            o_res_valid = 1'b1;
                            o_res.kind  = ((n_xor_even == 8'h00) && (n_xor_odd == 8'h00)) ?
                                          flbr_pkg::KIND_GOOD : flbr_pkg::KIND_BAD;
                            n_phase     = flbr_pkg::PH_HUNT;
                        end
                    end
                    default: begin
                        n_phase = flbr_pkg::PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte <= flbr_pkg::SYNC_RESET;
            r_gap_ticks <= flbr_pkg::GAP_RESET;
            r_phase     <= flbr_pkg::PH_HUNT;
            r_xor_even  <= 8'h00;
            r_xor_odd   <= 8'h00;
            r_sel       <= 1'b0;
            r_seq       <= 8'h00;
            r_len       <= 16'h0000;
            r_type      <= 8'h00;
            r_body      <= 17'd0;
            r_quiet     <= 16'd0;
        end else begin
            if (i_cfg_we && (i_cfg_addr == flbr_pkg::CFG_SYNC)) begin
                r_sync_byte <= i_cfg_wdata[7:0];
            end
            if (i_cfg_we && (i_cfg_addr == flbr_pkg::CFG_GAP)) begin
                r_gap_ticks <= i_cfg_wdata;
            end
            r_phase    <= n_phase;
            r_xor_even <= n_xor_even;
            r_xor_odd  <= n_xor_odd;
            r_sel      <= n_sel;
            r_seq      <= n_seq;
            r_len      <= n_len;
            r_type     <= n_type;
            r_body     <= n_body;
            r_quiet    <= n_quiet;
        end
    end

    `FLBR_ASSERT(a_res_needs_take, i_clk, i_rst_n, o_res_valid |-> o_take,
                 "result produced without a consumed word")
    `FLBR_ASSERT(a_verdict_rehunts, i_clk, i_rst_n,
                 (o_res_valid && (o_res.kind != flbr_pkg::KIND_PAYLOAD)) |=>
                 (r_phase == flbr_pkg::PH_HUNT),
                 "frame verdict did not return to hunting")
    `FLBR_ASSERT(a_body_in_range, i_clk, i_rst_n,
                 (r_phase == flbr_pkg::PH_BODY) |-> (r_body < total),
                 "body count ran past the frame end")
    `FLBR_ASSERT_NEVER(a_tick_no_res, i_clk, i_rst_n,
                       o_res_valid && (i_item.action == flbr_pkg::ACT_TICK),
                       "tick word produced a result")

endmodule

FILE: hw/rtl/flbr_out_reg.sv
// Result register on the master side; frees space as the current word leaves.
// Depends on flbr_pkg.
`include "framed_link_byte_receiver_top_macros.svh"
module flbr_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  flbr_pkg::t_result i_res,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output flbr_pkg::t_result o_res
);

    logic              r_valid;
    flbr_pkg::t_result r_res;

    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_push) begin
            r_res <= i_res;
        end
    end

    `FLBR_ASSERT(a_push_has_space, i_clk, i_rst_n, i_push |-> o_space,
                 "result pushed into a full output register")

endmodule

FILE: hw/rtl/framed_link_byte_receiver_top.sv
// Framed link byte receiver: input register, deframing core, result register.
// Depends on flbr_pkg, flbr_in_stage, flbr_core, flbr_out_reg.
//
// Slave channel: one word per received byte or time tick. tuser[0] is the
// action (0 byte, 1 tick) and tdata[7:0] the byte. Master channel: payload
// bytes as they arrive and one verdict word per frame; tuser[1:0] is the kind
// (0 payload, 1 checksum good, 2 checksum bad).
// Throughput is one word per cycle while the master side keeps up: the input
// register and the result register each hold a word, and the core computes each result combinationally.
// A word accepted into the input register has its result captured in the result
// register, and so shown on the master side, once that register has space.
// A word that yields no result still passes through the core.
// Reset (synchronous, active low) clears both registers, returns the
// receiver to hunting for sync and loads sync_byte = 0 and gap_ticks = 5000.
// When the master side stalls, the result register holds its word, the core
// waits with the next word in the input register and s_axis_tready falls
// once that register is full. Configuration writes take effect at the edge.
module framed_link_byte_receiver_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_data
    input  logic [0:0]  s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] payload_byte, [15:8] frame_type, [23:16] frame_sequence,
    // [39:24] frame_length
    output logic [39:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser    // [1:0] kind
);

    flbr_pkg::t_item   s_item;
    flbr_pkg::t_item   held_item;
    flbr_pkg::t_result core_res;
    flbr_pkg::t_result out_res;
    logic              held_valid;
    logic              take;
    logic              space;
    logic              res_valid;

    assign s_item.action  = s_axis_tuser[0];
    assign s_item.rx_data = s_axis_tdata;

    flbr_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (s_item),
        .i_take  (take),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    flbr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (held_valid),
        .i_item      (held_item),
        .i_space     (space),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (core_res)
    );

    flbr_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (core_res),
        .o_space (space),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tuser = out_res.kind;
    assign m_axis_tdata = {out_res.frame_length, out_res.frame_sequence,
                           out_res.frame_type, out_res.payload_byte};

endmodule

FILE: dv/tb.sv
// Self-checking bench for framed_link_byte_receiver_top: directed table, then random frames.
// Depends on flbr_pkg and the block RTL; the predictor is built in, results are checked in order.
module tb;

    localparam int STALL_LIMIT = 1000;

    typedef struct {
        logic              act;
        logic [7:0]        b;
        bit                pinned;
        flbr_pkg::t_result r;
    } t_step;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_addr    = flbr_pkg::CFG_SYNC;
    logic [15:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic [0:0]  s_axis_tuser  = flbr_pkg::ACT_BYTE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // predictor state and register copies
    flbr_pkg::t_phase rx_ph     = flbr_pkg::PH_HUNT;
    logic [7:0]  lane_x [2] = '{8'h00, 8'h00};
    logic        lane_pick = 1'b0;
    logic [7:0]  seq_q     = '0;
    logic [15:0] len_q     = '0;
    logic [7:0]  type_q    = '0;
    logic [16:0] body_cnt  = '0;
    logic [15:0] gap_count = '0;
    logic [7:0]  cfg_sync  = flbr_pkg::SYNC_RESET;
    logic [15:0] cfg_gap   = flbr_pkg::GAP_RESET;

    flbr_pkg::t_result due_results [$];
    t_step       opening [24];
    int          fails        = 0;
    int          words_sent   = 0;
    int          src_idle     = 32;
    int          snk_idle     = 46;
    int          quiet_cycles = 0;

    framed_link_byte_receiver_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void take_lead(input logic [7:0] b);
        if (b == cfg_sync) begin
            lane_x[0] = b;
            lane_x[1] = 8'h00;
            lane_pick = 1'b1;
            rx_ph = flbr_pkg::PH_SEQ;
        end else begin
            rx_ph = flbr_pkg::PH_DISCARD;
            gap_count = '0;
        end
    endfunction

    function automatic bit deframe_word(input logic act, input logic [7:0] b,
                                        output flbr_pkg::t_result r);
        logic [16:0] span;
        r = '0;
        if (act == flbr_pkg::ACT_TICK) begin
            if (rx_ph == flbr_pkg::PH_DISCARD && gap_count != 16'hFFFF)
                gap_count++;
            return 1'b0;
        end
        lane_x[lane_pick] ^= b;
        lane_pick = ~lane_pick;
        case (rx_ph)
            flbr_pkg::PH_DISCARD: begin
                if (gap_count < cfg_gap)
                    gap_count = '0;
                else
                    take_lead(b);
            end
            flbr_pkg::PH_HUNT: take_lead(b);
            flbr_pkg::PH_SEQ: begin
                seq_q = b;
                rx_ph = flbr_pkg::PH_LEN_HI;
            end
            flbr_pkg::PH_LEN_HI: begin
                len_q = {b, 8'h00};
                rx_ph = flbr_pkg::PH_LEN_LO;
            end
            flbr_pkg::PH_LEN_LO: begin
                len_q[7:0] = b;
                rx_ph = flbr_pkg::PH_TYPE;
            end
            flbr_pkg::PH_TYPE: begin
                type_q = b;
                rx_ph = flbr_pkg::PH_RESERVED;
            end
            flbr_pkg::PH_RESERVED: begin
                body_cnt = '0;
                rx_ph = flbr_pkg::PH_BODY;
            end
            default: begin
                span = ({1'b0, len_q} + flbr_pkg::LEN_PAD) & ~17'd1;
                if (body_cnt < {1'b0, len_q}) begin
                    body_cnt++;
                    r = '{flbr_pkg::KIND_PAYLOAD, b, type_q, seq_q, len_q};
                    return 1'b1;
                end
                body_cnt++;
                if (body_cnt >= span) begin
                    rx_ph = flbr_pkg::PH_HUNT;
                    r = '{(lane_x[0] == 8'h00 && lane_x[1] == 8'h00) ? flbr_pkg::KIND_GOOD
                                                                     : flbr_pkg::KIND_BAD,
                          8'h00, type_q, seq_q, len_q};
                    return 1'b1;
                end
            end
        endcase
        return 1'b0;
    endfunction

    task automatic send_word(input logic act, input logic [7:0] b,
                             input bit pinned = 1'b0,
                             input flbr_pkg::t_result pinned_r = '0);
        flbr_pkg::t_result r;
        bit      hit;
        while ($urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        hit = deframe_word(act, b, r);
        if (pinned)
            due_results.push_back(pinned_r);
        else if (hit)
            due_results.push_back(r);
        words_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic configure(input logic [7:0] sync, input logic [15:0] gap);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= flbr_pkg::CFG_SYNC;
        i_cfg_wdata <= {8'h00, sync};
        @(posedge i_clk);
        i_cfg_addr  <= flbr_pkg::CFG_GAP;
        i_cfg_wdata <= gap;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_sync = sync;
        cfg_gap  = gap;
    endtask

    // leaves the receiver ready to take a sync byte
    task automatic reach_hunt();
        while (rx_ph != flbr_pkg::PH_HUNT && rx_ph != flbr_pkg::PH_DISCARD)
            send_word(flbr_pkg::ACT_BYTE,
                      rx_ph == flbr_pkg::PH_LEN_HI ? 8'h00 : 8'($urandom));
        if (rx_ph == flbr_pkg::PH_DISCARD && cfg_gap != 0 && cfg_gap <= 16 &&
            $urandom_range(2) == 0) begin
            repeat ($urandom_range(cfg_gap - 1)) send_word(flbr_pkg::ACT_TICK, 8'($urandom));
            send_word(flbr_pkg::ACT_BYTE, cfg_sync);
        end
        while (rx_ph == flbr_pkg::PH_DISCARD && gap_count < cfg_gap)
            send_word(flbr_pkg::ACT_TICK, 8'($urandom));
        repeat ($urandom_range(1)) send_word(flbr_pkg::ACT_TICK, 8'($urandom));
    endtask

    task automatic send_frame(input logic [15:0] len, input bit spoil, input int keep);
        logic [7:0] fb [$];
        logic [7:0] ev;
        logic [7:0] od;
        ev = 8'h00;
        od = 8'h00;
        fb = {cfg_sync, 8'($urandom), len[15:8], len[7:0], 8'($urandom), 8'($urandom)};
        repeat (len) fb.push_back(8'($urandom));
        if (len[0])
            fb.push_back(8'($urandom));
        for (int i = 0; i < fb.size(); i++) begin
            if (i % 2 == 1)
                od ^= fb[i];
            else
                ev ^= fb[i];
        end
        fb.push_back(ev);
        fb.push_back(od);
        if (spoil)
            fb[$urandom_range(6, fb.size() - 1)] ^= 8'($urandom_range(1, 255));
        for (int i = 0; i < fb.size() && i < keep; i++) begin
            if ($urandom_range(19) == 0)
                send_word(flbr_pkg::ACT_TICK, 8'($urandom));
            send_word(flbr_pkg::ACT_BYTE, fb[i]);
        end
    endtask

    task automatic random_words(input bit noisy);
        int stop;
        int pick;
        stop = words_sent + 270;
        while (words_sent < stop) begin
            pick = $urandom_range(99);
            if (noisy && pick >= 80 && pick < 92) begin
                repeat ($urandom_range(1, 4)) send_word(flbr_pkg::ACT_BYTE, 8'($urandom));
            end else if (pick >= 92) begin
                repeat ($urandom_range(1, 8)) send_word(flbr_pkg::ACT_TICK, 8'($urandom));
            end else begin
                reach_hunt();
                send_frame(($urandom_range(3) == 0) ? 16'($urandom_range(1))
                                                    : 16'($urandom_range(2, 40)),
                           $urandom_range(7) == 0,
                           (pick >= 70 && pick < 80) ? $urandom_range(1, 6) : 1 << 20);
            end
        end
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        flbr_pkg::t_result want;
        m_axis_tready <= ($urandom_range(99) >= snk_idle);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected word, expected none, got kind %0d data %h",
                         $time, m_axis_tuser, m_axis_tdata);
                fails++;
            end else begin
                want = due_results.pop_front();
                check_field("kind", want.kind, m_axis_tuser);
                check_field("payload_byte", want.payload_byte, m_axis_tdata[7:0]);
                check_field("frame_type", want.frame_type, m_axis_tdata[15:8]);
                check_field("frame_sequence", want.frame_sequence, m_axis_tdata[23:16]);
                check_field("frame_length", want.frame_length, m_axis_tdata[39:24]);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        // reset registers: sync 0x00, gap 5000
        opening = '{
            '{flbr_pkg::ACT_TICK, 8'hFF, 1'b0, '0},
            '{flbr_pkg::ACT_BYTE, 8'h00, 1'b0, '0},
            '{flbr_pkg::ACT_BYTE, 8'hFF, 1'b0, '0},
            '{flbr_pkg::ACT_BYTE, 8'h00, 1'b0, '0},
            '{flbr_pkg::ACT_BYTE, 8'h01, 1'b0, '0},
            '{flbr_pkg::ACT_BYTE, 8'h80, 1'b0, '0},
            '{flbr_pkg::ACT_BYTE, 8'h00, 1'b0, '0},
            '{flbr_pkg::ACT_BYTE, 8'h7E, 1'b1,
              '{flbr_pkg::KIND_PAYLOAD, 8'h7E, 8'h80, 8'hFF, 16'd1}},
            '{flbr_pkg::ACT_BYTE, 8'h00, 1'b0, '0},
            '{flbr_pkg::ACT_BYTE, 8'hFE, 1'b0, '0},
            '{flbr_pkg::ACT_BYTE, 8'hFE, 1'b1,
              '{flbr_pkg::KIND_GOOD, 8'h00, 8'h80, 8'hFF, 16'd1}},
            '{flbr_pkg::ACT_BYTE, 8'h00, 1'b0, '0},
            '{flbr_pkg::ACT_BYTE, 8'h00, 1'b0, '0},
            '{flbr_pkg::ACT_BYTE, 8'h00, 1'b0, '0},
            '{flbr_pkg::ACT_BYTE, 8'h00, 1'b0, '0},
            '{flbr_pkg::ACT_BYTE, 8'hFF, 1'b0, '0},
            '{flbr_pkg::ACT_BYTE, 8'h00, 1'b0, '0},
            '{flbr_pkg::ACT_TICK, 8'h00, 1'b0, '0},
            '{flbr_pkg::ACT_BYTE, 8'h00, 1'b0, '0},
            '{flbr_pkg::ACT_BYTE, 8'h00, 1'b1,
              '{flbr_pkg::KIND_BAD, 8'h00, 8'hFF, 8'h00, 16'd0}},
            '{flbr_pkg::ACT_BYTE, 8'h5A, 1'b0, '0},
            '{flbr_pkg::ACT_TICK, 8'h00, 1'b0, '0},
            '{flbr_pkg::ACT_BYTE, 8'h00, 1'b0, '0},
            '{flbr_pkg::ACT_TICK, 8'h00, 1'b0, '0}
        };
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening[i])
            send_word(opening[i].act, opening[i].b, opening[i].pinned, opening[i].r);

        configure(8'hFF, 16'd0);
        random_words(1'b1);
        configure(8'h5A, 16'd3);
        random_words(1'b1);

        src_idle = 46;
        snk_idle = 32;
        configure(8'($urandom), 16'($urandom_range(1, 12)));
        random_words(1'b1);
        // end in hunting so the widest gap is never waited out
        reach_hunt();
        send_frame(16'd4, 1'b0, 1 << 20);
        configure(8'h00, 16'hFFFF);
        random_words(1'b0);

        src_idle = 0;
        snk_idle = 0;
        configure(8'($urandom), 16'd1);
        reach_hunt();
        send_frame(16'h0103, 1'b0, 1 << 20);
        random_words(1'b1);
        configure(8'hC3, 16'd2);
        random_words(1'b1);

        drain();
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
